>>> rtl/core/sdf_pkg.sv
// sdf_pkg: shared types, constants and the alphabet symbol lookup for the
// signed radix digit formatter. No dependencies; imported by every rtl/core module.

package sdf_pkg;

  localparam int MAX_SYMBOLS = 16;
  localparam int DIGIT_SLOTS = 32;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // configuration register indexes
  localparam logic [1:0] REG_ALPHA_LO = 2'd0;
  localparam logic [1:0] REG_ALPHA_HI = 2'd1;

  typedef logic [4:0] radix_t;

  // one formatting job handed from front to back
  typedef struct packed {
    logic        negative;
    logic [31:0] magnitude;
    radix_t      radix;
  } sdf_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sdf_qstat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SIGN,
    BK_READ,
    BK_EMIT
  } sdf_back_state_t;

  // symbol at position pos, symbols 0..7 in lo, 8..15 in hi
  function automatic logic [7:0] symbol_at(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [3:0] pos);
    logic [63:0] w;
    w = pos[3] ? hi : lo;
    return w[{pos[2:0], 3'b000} +: 8];
  endfunction

endpackage

>>> rtl/core/sdf_front.sv
// sdf_front: accepts numbers, checks the alphabet and forms sign and magnitude.
// Depends on sdf_pkg; pushes jobs into sdf_queue.

module sdf_front import sdf_pkg::*; (
  input  logic [63:0]        alpha_lo,
  input  logic [63:0]        alpha_hi,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] number,
  input  sdf_qstat_t         q_status,
  output logic               push,
  output sdf_job_t           job
);

  // radix of the alphabet, zero when it is unusable
  function automatic radix_t alphabet_radix(input logic [63:0] lo, input logic [63:0] hi);
    logic [MAX_SYMBOLS-1:0] zero;
    radix_t                 len;
    logic                   bad;
    logic [7:0]             sa;
    zero = '0;
    len  = 5'(MAX_SYMBOLS);
    bad  = 1'b0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      zero[i] = (symbol_at(lo, hi, 4'(i)) == 8'd0);
    end
    // first zero byte ends the alphabet
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if (zero[i]) len = 5'(i);
    end
    for (int a = 0; a < MAX_SYMBOLS; a++) begin
      sa = symbol_at(lo, hi, 4'(a));
      if (5'(a) < len) begin
        if (sa == CHAR_PLUS || sa == CHAR_MINUS) bad = 1'b1;
        for (int b = a + 1; b < MAX_SYMBOLS; b++) begin
          if (5'(b) < len && symbol_at(lo, hi, 4'(b)) == sa) bad = 1'b1;
        end
      end
    end
    if (len < 5'd2 || bad) return '0;
    return len;
  endfunction

  radix_t      radix;
  logic [31:0] raw;

  assign raw      = $unsigned(number);
  assign radix    = alphabet_radix(alpha_lo, alpha_hi);
  assign in_stall = q_status.full;

  // a word with an unusable alphabet is taken and dropped
  assign push = in_valid && !q_status.full && (radix != '0);

  assign job.negative  = raw[31];
  assign job.magnitude = raw[31] ? (32'd0 - raw) : raw;
  assign job.radix     = radix;

endmodule

>>> rtl/core/sdf_queue.sv
// sdf_queue: two-entry job queue between the front and back parts.
// Depends on sdf_pkg.

module sdf_queue import sdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  sdf_job_t   push_job,
  input  logic       pop,
  output sdf_job_t   pop_job,
  output sdf_qstat_t status
);

  sdf_job_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  assign pop_job      = slots[rd_ptr];
  assign status.empty = (count == 2'd0);
  assign status.full  = (count == 2'd2);

endmodule

>>> rtl/core/sdf_back.sv
// sdf_back: divides the magnitude down digit by digit into a digit memory,
// then emits sign and symbols most significant first. Depends on sdf_pkg.

module sdf_back import sdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] alpha_lo,
  input  logic [63:0] alpha_hi,
  input  sdf_qstat_t  q_status,
  input  sdf_job_t    pop_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  character,
  output logic        last
);

  localparam int STEPS_PER_CYCLE = 8;
  // final cycle of one 32-bit division pass
  localparam logic [1:0] LAST_STEP = 2'(32 / STEPS_PER_CYCLE - 1);

  sdf_back_state_t state, state_next;

  logic [31:0] work;
  logic [31:0] work_next;
  logic [4:0]  rem;
  logic [4:0]  rem_next;
  logic [4:0]  rem_shift;
  logic        qbit;
  radix_t      radix;
  logic        negative;
  logic [1:0]  step;
  logic [5:0]  count;
  logic [5:0]  count_m1;
  logic [4:0]  rd_addr;
  logic [3:0]  rd_data;
  logic [3:0]  digit_store [DIGIT_SLOTS];

  logic slot_free;
  logic div_en;
  logic digit_done;
  logic out_load;
  logic emit_dec;

  // eight restoring division steps a cycle, remainder stays below radix
  always_comb begin
    rem_next  = rem;
    work_next = work;
    rem_shift = '0;
    qbit      = 1'b0;
    for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
      rem_shift = {rem_next[3:0], work_next[31]};
      qbit      = (rem_shift >= radix);
      rem_next  = qbit ? (rem_shift - radix) : rem_shift;
      work_next = {work_next[30:0], qbit};
    end
  end

  assign slot_free = !out_valid || !out_stall;
  assign count_m1  = count - 6'd1;
  assign rd_addr   = count_m1[4:0];

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!q_status.empty) state_next = BK_DIV;
      BK_DIV: begin
        if (step == LAST_STEP) begin
          if (work_next != '0 && count < 6'(DIGIT_SLOTS - 1)) state_next = BK_DIV;
          else if (negative) state_next = BK_SIGN;
          else state_next = BK_READ;
        end
      end
      BK_SIGN: if (slot_free) state_next = BK_READ;
      BK_READ: state_next = BK_EMIT;
      BK_EMIT: begin
        if (slot_free) state_next = (count == 6'd1) ? BK_IDLE : BK_READ;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    div_en     = 1'b0;
    digit_done = 1'b0;
    out_load   = 1'b0;
    emit_dec   = 1'b0;
    unique case (state)
      BK_IDLE: pop = !q_status.empty;
      BK_DIV: begin
        div_en     = 1'b1;
        digit_done = (step == LAST_STEP);
      end
      BK_SIGN: out_load = slot_free;
      BK_READ: ;
      BK_EMIT: begin
        out_load = slot_free;
        emit_dec = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      step  <= 2'd0;
      count <= '0;
    end else begin
      state <= state_next;
      if (pop) begin
        step  <= 2'd0;
        count <= '0;
      end else if (div_en) begin
        step <= step + 2'd1;
        if (digit_done) count <= count + 6'd1;
      end else if (emit_dec) begin
        count <= count_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work     <= pop_job.magnitude;
      rem      <= '0;
      radix    <= pop_job.radix;
      negative <= pop_job.negative;
    end else if (div_en) begin
      work <= work_next;
      rem  <= digit_done ? 5'd0 : rem_next;
    end
  end

  // digit memory, least significant digit at address zero
  always_ff @(posedge clk) begin
    if (digit_done) digit_store[count[4:0]] <= rem_next[3:0];
    rd_data <= digit_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      character <= (state == BK_SIGN) ? CHAR_MINUS : symbol_at(alpha_lo, alpha_hi, rd_data);
      last      <= (state == BK_EMIT) && (count == 6'd1);
    end
  end

endmodule

>>> rtl/core/signed_radix_digit_formatter.sv
// channel | direction | signals                 | handshake
// input   | in        | number                  | in_valid / in_stall
// output  | out       | character, last         | out_valid / out_stall
// config  | in        | cfg_index, cfg_data     | cfg_we, no wait
//
// a number is taken when the queue is not full and queued (two jobs deep) for the back end
// each digit takes one full division pass in the shared divider (8 quotient bits a cycle),
// each output character goes through a digit memory read, then the output register
// and a negative number sends a '-' before its digits
// rst is synchronous and clears control state and the alphabet registers
// the output register holds its word under out_stall; in_stall rises only when the queue is full
//
// Top level of the signed radix digit formatter; depends on sdf_pkg,
// sdf_front, sdf_queue and sdf_back.

module signed_radix_digit_formatter import sdf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] number,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         character,
  output logic               last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [63:0] alpha_lo;
  logic [63:0] alpha_hi;
  logic        q_push;
  logic        q_pop;
  sdf_job_t    push_job;
  sdf_job_t    pop_job;
  sdf_qstat_t  q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_lo <= '0;
      alpha_hi <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA_LO: alpha_lo <= cfg_data;
        REG_ALPHA_HI: alpha_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  sdf_front u_front (
    .alpha_lo (alpha_lo),
    .alpha_hi (alpha_hi),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .number   (number),
    .q_status (q_status),
    .push     (q_push),
    .job      (push_job)
  );

  sdf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  sdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .alpha_lo  (alpha_lo),
    .alpha_hi  (alpha_hi),
    .q_status  (q_status),
    .pop_job   (pop_job),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("job popped from an empty queue");

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue both full and empty");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word valid after reset");

endmodule
